FILE: rtl/core/assert_macros.svh
// Assertion macros for the port-level checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/core/b64e_pkg.sv
// Shared types and constants of the base64 encoder.
package b64e_pkg;

  // Alphabet register file
  localparam int unsigned ALPHA_WORDS = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // Default depth of the job queue between front and back
  localparam int unsigned JOBQ_DEPTH  = 2;

  // Padding character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Characters per 4-symbol group
  localparam int unsigned GROUP_CHARS = 4;

  // Position within the current three-byte group
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_ONE   = 3'b010,
    PH_TWO   = 3'b100
  } phase_e;

  // One job: the characters caused by one input byte
  typedef struct packed {
    logic [GROUP_CHARS-1:0][5:0] sym;      // symbol index per character
    logic [GROUP_CHARS-1:0]      pad;      // character is '=' padding
    logic [1:0]                  last_idx; // index of the job's last character
    logic                        fin;      // job ends the message
  } job_t;

endpackage

FILE: rtl/core/b64e_jobq.sv
// Small register queue holding jobs between the front and the back.
module b64e_jobq #(
  parameter int unsigned Depth = b64e_pkg::JOBQ_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output b64e_pkg::job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/b64e_front.sv
// Front end: accepts bytes, tracks the group position and builds one job per byte.
module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     data_byte_i,
  input  logic           final_byte_i,
  input  logic           jobq_full_i,
  output logic           jobq_push_o,
  output b64e_pkg::job_t job_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       left_q, left_d;
  logic             accept;

  assign accept      = push_i && !jobq_full_i;
  assign jobq_push_o = accept;

  // Split the byte into symbol indexes for the current group position
  always_comb begin
    job_o     = '0;
    job_o.fin = final_byte_i;
    phase_d   = phase_q;
    left_d    = left_q;
    case (phase_q)
      b64e_pkg::PH_ONE: begin
        job_o.sym[0] = {left_q[1:0], data_byte_i[7:4]};
        if (final_byte_i) begin
          job_o.sym[1]   = {data_byte_i[3:0], 2'b00};
          job_o.pad[2]   = 1'b1;
          job_o.last_idx = 2'd2;
          phase_d        = b64e_pkg::PH_START;
          left_d         = '0;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = b64e_pkg::PH_TWO;
          left_d         = data_byte_i[3:0];
        end
      end
      b64e_pkg::PH_TWO: begin
        job_o.sym[0]   = {left_q, data_byte_i[7:6]};
        job_o.sym[1]   = data_byte_i[5:0];
        job_o.last_idx = 2'd1;
        phase_d        = b64e_pkg::PH_START;
        left_d         = '0;
      end
      default: begin
        // start of a group
        job_o.sym[0] = data_byte_i[7:2];
        if (final_byte_i) begin
          job_o.sym[1]   = {data_byte_i[1:0], 4'b0000};
          job_o.pad[2]   = 1'b1;
          job_o.pad[3]   = 1'b1;
          job_o.last_idx = 2'd3;
          phase_d        = b64e_pkg::PH_START;
          left_d         = '0;
        end else begin
          job_o.last_idx = 2'd0;
          phase_d        = b64e_pkg::PH_ONE;
          left_d         = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PH_START;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: rtl/core/b64e_back.sv
// Back end: holds the alphabet, walks each job one character a cycle into the output register while it is free.
module b64e_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [b64e_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              jobq_valid_i,
  input  b64e_pkg::job_t                    jobq_data_i,
  output logic                              jobq_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [7:0]                        out_char_o,
  output logic                              last_char_o
);

  logic [b64e_pkg::CFG_DATA_W-1:0] alpha_q [b64e_pkg::ALPHA_WORDS];

  b64e_pkg::job_t job_q, job_d;
  logic           job_valid_q, job_valid_d;
  logic [1:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_char_q, out_char_d;
  logic           out_last_q, out_last_d;

  logic                            adv, done;
  logic [5:0]                      cur_sym;
  logic [b64e_pkg::CFG_DATA_W-1:0] cur_word;
  logic [7:0]                      sym_char;

  assign empty_o     = !out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

  // Alphabet lookup for the current character
  assign cur_sym  = job_q.sym[idx_q];
  assign cur_word = alpha_q[cur_sym[5:3]];
  assign sym_char = cur_word[{cur_sym[2:0], 3'b000} +: 8];

  // Output register frees up when empty or when its result transfers
  assign adv        = !out_valid_q || pop_i;
  assign done       = (idx_q == job_q.last_idx);
  assign jobq_pop_o = jobq_valid_i && (!job_valid_q || (adv && done));

  // Character sequencing
  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = job_valid_q;
      out_char_d  = job_q.pad[idx_q] ? b64e_pkg::PAD_CHAR : sym_char;
      out_last_d  = job_q.fin && done;
      if (job_valid_q && !done) begin
        idx_d = idx_q + 1'b1;
      end else if (job_valid_q) begin
        job_valid_d = 1'b0;
      end
    end
    if (jobq_pop_o) begin
      job_d       = jobq_data_i;
      job_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Alphabet registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < b64e_pkg::ALPHA_WORDS; i++) begin
        alpha_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      alpha_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

endmodule

FILE: rtl/core/base64_encoder_custom_alphabet.sv
// Base64 encoder with a configurable alphabet: top level.
// Bytes go in through a push/full port and encoded characters come out through
// an empty/pop port, one character per clock at most; the back end's character
// sequencer sets that rate. A byte causes one or two characters, a final byte
// two to four including '=' padding. A byte passes through the job queue, the
// job register and the output register before its first character shows. The
// front end parses bytes into jobs without waiting on the output; a job queue
// of JobQDepth entries lets it run ahead while the output is stalled. The
// alphabet is eight 64-bit words (symbol k of word w is byte k, low byte
// first), all zero after reset; the user must write it only while the encoder
// is idle, as the block itself does not enforce this.
module base64_encoder_custom_alphabet #(
  parameter int unsigned JobQDepth = b64e_pkg::JOBQ_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [b64e_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      data_byte_i,
  input  logic                            final_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_char_o,
  output logic                            last_char_o
);

  b64e_pkg::job_t front_job, jobq_data;
  logic           jobq_push, jobq_full, jobq_valid, jobq_pop;

  assign full = jobq_full;

  // Byte parser
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .jobq_full_i  (jobq_full),
    .jobq_push_o  (jobq_push),
    .job_o        (front_job)
  );

  // Job queue
  b64e_jobq #(
    .Depth (JobQDepth)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jobq_push),
    .data_i  (front_job),
    .full_o  (jobq_full),
    .pop_i   (jobq_pop),
    .valid_o (jobq_valid),
    .data_o  (jobq_data)
  );

  // Character emitter
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .jobq_valid_i (jobq_valid),
    .jobq_data_i  (jobq_data),
    .jobq_pop_o   (jobq_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

FILE: rtl/core/b64e_checker.sv
// Port-level checker for the base64 encoder, bound to the top level.
`include "assert_macros.svh"

module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       last_char_o
);

  logic       seen_q;
  logic [1:0] ocnt_q;
  logic       out_xfer;
  logic [8:0] out_word;

  assign out_xfer = pop && !empty;
  assign out_word = {last_char_o, out_char_o};

  // Any input transfer seen since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push && !full) begin
      seen_q <= 1'b1;
    end
  end

  // Characters transferred within the current 4-character group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else if (out_xfer) begin
      ocnt_q <= last_char_o ? 2'd0 : ocnt_q + 1'b1;
    end
  end

  // A waiting result holds until it transfers
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_word)))

  // Nothing to read while in reset
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> empty)

  // No character before the first byte
  `ASSERT_RST(a_no_spurious, clk_i, rst_ni, !empty |-> seen_q)

  // An encoded message is a whole number of 4-character groups
  `ASSERT_RST(a_group_len, clk_i, rst_ni, (out_xfer && last_char_o) |-> (ocnt_q == 2'd3))

endmodule

bind base64_encoder_custom_alphabet b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_char_o  (out_char_o),
  .last_char_o (last_char_o)
);

FILE: tb/b64e_stream_checker.sv
// Checker for the base64 encoder: predicts the character stream and compares it.
module b64e_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [b64e_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            final_byte_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic [7:0]                      out_char_i,
  input  logic                            last_char_i,
  output int                              mismatch_cnt_o,
  output int                              pending_o,
  output int                              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Shadow alphabet and encoder state
  logic [b64e_pkg::CFG_DATA_W-1:0] alphabet [b64e_pkg::ALPHA_WORDS];
  b64e_pkg::phase_e                group_phase;
  logic [3:0]                      leftover;
  enc_char_t                       expected_chars_q [$];

  function automatic logic [7:0] symbol_at(input logic [5:0] idx);
    return alphabet[idx[5:3]][{idx[2:0], 3'b000} +: 8];
  endfunction

  task automatic expect_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    expected_chars_q.push_back(e);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_cnt_o++;
  endtask

  // Characters caused by one byte, MSBs first; final byte flushes and pads
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (group_phase)
      b64e_pkg::PH_ONE: begin
        expect_char(symbol_at({leftover[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          expect_char(symbol_at({b[3:0], 2'b00}), 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b1);
          group_phase = b64e_pkg::PH_START;
          leftover    = '0;
        end else begin
          leftover    = b[3:0];
          group_phase = b64e_pkg::PH_TWO;
        end
      end
      b64e_pkg::PH_TWO: begin
        expect_char(symbol_at({leftover, b[7:6]}), 1'b0);
        expect_char(symbol_at(b[5:0]), fin);
        group_phase = b64e_pkg::PH_START;
        leftover    = '0;
      end
      default: begin
        expect_char(symbol_at(b[7:2]), 1'b0);
        if (fin) begin
          expect_char(symbol_at({b[1:0], 4'b0000}), 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b1);
          group_phase = b64e_pkg::PH_START;
          leftover    = '0;
        end else begin
          leftover    = {2'b00, b[1:0]};
          group_phase = b64e_pkg::PH_ONE;
        end
      end
    endcase
  endtask

  // Monitor: config writes, output transfers, then input transfers
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    enc_char_t want;
    if (!rst_ni) begin
      for (int w = 0; w < b64e_pkg::ALPHA_WORDS; w++) alphabet[w] = '0;
      group_phase = b64e_pkg::PH_START;
      leftover    = '0;
      expected_chars_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      checked_o      = 0;
    end else begin
      if (cfg_we_i) alphabet[cfg_idx_i] = cfg_wdata_i;
      // a character popped now was caused by an earlier byte
      if (pop_i && !empty_i) begin
        checked_o++;
        if (expected_chars_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character %02h last %0b",
                                    out_char_i, last_char_i));
        end else begin
          want = expected_chars_q.pop_front();
          if (out_char_i !== want.ch)
            report_mismatch($sformatf("out_char got %02h want %02h", out_char_i, want.ch));
          if (last_char_i !== want.last)
            report_mismatch($sformatf("last_char got %0b want %0b (char %02h)",
                                      last_char_i, want.last, want.ch));
        end
      end
      if (push_i && !full_i) encode_byte(data_byte_i, final_byte_i);
      pending_o = expected_chars_q.size();
    end
  end

endmodule

FILE: tb/base64_encoder_custom_alphabet_tb.sv
// Testbench top for the base64 encoder: stimulus, flow control and verdict.
module base64_encoder_custom_alphabet_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseBytes  = 32;
  localparam int unsigned NumPhases   = 4;

  typedef enum int {ALPHA_STD, ALPHA_ONES, ALPHA_RAND} alpha_mode_e;
  typedef logic [7:0] byte_q_t [$];

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [b64e_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            push;
  logic                            full;
  logic [7:0]                      data_byte;
  logic                            final_byte;
  logic                            empty;
  logic                            pop;
  logic [7:0]                      out_char;
  logic                            last_char;

  int mismatch_cnt;
  int pending;
  int checked;
  int bytes_sent;
  int msgs_sent;
  int send_idle_pct;
  int pop_stall_pct;
  int quiet_cycles;

  int          idle_pcts  [NumPhases] = '{0, 75, 0, 38};
  int          stall_pcts [NumPhases] = '{0, 0, 75, 38};
  alpha_mode_e phase_alpha[NumPhases] = '{ALPHA_STD, ALPHA_ONES, ALPHA_RAND, ALPHA_RAND};

  base64_encoder_custom_alphabet dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte),
    .final_byte_i (final_byte),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char),
    .last_char_o  (last_char)
  );

  b64e_stream_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push_i         (push),
    .full_i         (full),
    .data_byte_i    (data_byte),
    .final_byte_i   (final_byte),
    .empty_i        (empty),
    .pop_i          (pop),
    .out_char_i     (out_char),
    .last_char_i    (last_char),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random stalls per the current mix
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = rst_n && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog: cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d chars outstanding",
               $time, QuietLimit, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Biased toward the extreme byte values
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Word w of the alphabet for a given setting
  function automatic logic [63:0] alphabet_word(input alpha_mode_e mode, input int w);
    logic [63:0] word;
    int          idx;
    logic [7:0]  ch;
    word = '0;
    case (mode)
      ALPHA_ONES: word = '1;
      ALPHA_RAND: word = {32'($urandom), 32'($urandom)};
      default: begin
        for (int k = 0; k < 8; k++) begin
          idx = 8 * w + k;
          if (idx < 26)      ch = 8'(8'h41 + idx);
          else if (idx < 52) ch = 8'(8'h61 + idx - 26);
          else if (idx < 62) ch = 8'(8'h30 + idx - 52);
          else if (idx == 62) ch = 8'h2B;
          else               ch = 8'h2F;
          word[8*k +: 8] = ch;
        end
      end
    endcase
    return word;
  endfunction

  task automatic write_alphabet(input alpha_mode_e mode);
    for (int w = 0; w < b64e_pkg::ALPHA_WORDS; w++) begin
      cfg_we    = 1'b1;
      cfg_idx   = b64e_pkg::CFG_IDX_W'(w);
      cfg_wdata = alphabet_word(mode, w);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // One byte transfer; random data shows on the bus while idle
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      push       = 1'b0;
      data_byte  = 8'($urandom_range(255));
      final_byte = 1'($urandom_range(1));
      @(negedge clk);
    end
    push       = 1'b1;
    data_byte  = b;
    final_byte = fin;
    do @(posedge clk); while (full);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg(input byte_q_t msg);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msgs_sent++;
  endtask

  // Wait until every expected character has come out, then let the pipe settle
  task automatic wait_drained();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin : stimulus
    byte_q_t msg;
    int      phase_start;
    int      len;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    push          = 1'b0;
    data_byte     = '0;
    final_byte    = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    bytes_sent    = 0;
    msgs_sent     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Unconfigured alphabet: every symbol reads as zero
    msg = {8'hFF};
    send_msg(msg);
    wait_drained();
    write_alphabet(ALPHA_STD);

    // Directed: both paddings, no padding, byte extremes, multi-group
    msg = {8'h00};
    send_msg(msg);
    msg = {8'hFF, 8'h00};
    send_msg(msg);
    msg = {8'h4D, 8'h61, 8'h6E};
    send_msg(msg);
    msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg(msg);
    msg = {8'h00, 8'h80, 8'h01, 8'hFE, 8'h7F};
    send_msg(msg);

    // Random messages under each flow-control mix and alphabet
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      send_idle_pct = idle_pcts[ph];
      pop_stall_pct = stall_pcts[ph];
      write_alphabet(phase_alpha[ph]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        len = $urandom_range(1, 7);
        msg.delete();
        for (int i = 0; i < len; i++) msg.push_back(rand_byte());
        send_msg(msg);
      end
    end

    wait_drained();
    $display("Summary: %0d bytes in %0d messages, %0d characters checked, %0d mismatches",
             bytes_sent, msgs_sent, checked, mismatch_cnt);
    $display("Summary: reset, standard, all-ones and random alphabets; four flow-control mixes");
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
